// ----- rtl/chbl_pkg.sv -----
// Package for the chunked body length checker: widths, phase and status codes,
// character constants and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package chbl_pkg;

	localparam int SIZE_WIDTH  = 32;
	localparam int TOTAL_WIDTH = 32;
	localparam int SUM_WIDTH   = ((SIZE_WIDTH > TOTAL_WIDTH) ? SIZE_WIDTH : TOTAL_WIDTH) + 1;
	localparam int LEN_OUT_W   = 32;
	localparam int EXT_W       = 64;

	typedef logic [SIZE_WIDTH-1:0]  size_t;
	typedef logic [TOTAL_WIDTH-1:0] total_t;
	typedef logic [SUM_WIDTH-1:0]   sum_t;

	typedef enum logic [2:0] {
		PH_DIGITS  = 3'd0,
		PH_SIZE_LF = 3'd1,
		PH_DATA    = 3'd2,
		PH_DATA_CR = 3'd3,
		PH_DATA_LF = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY      = 2'd0,
		ST_DONE      = 2'd1,
		ST_SIZE_ERR  = 2'd2,
		ST_FRAME_ERR = 2'd3
	} status_t;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	// Decode one lowercase hex digit.
	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h.ok    = 1'b0;
		h.value = 4'd0;
		if (b >= "0" && b <= "9") begin
			h.ok    = 1'b1;
			h.value = 4'(b - 8'h30);
		end else if (b >= "a" && b <= "f") begin
			h.ok    = 1'b1;
			h.value = 4'(b - 8'h57);
		end
		return h;
	endfunction

endpackage

// ----- rtl/chbl_if.sv -----
// Stream interfaces of the chunked body length checker: body bytes in,
// status and running length out. Depends on chbl_pkg.
`timescale 1ns / 1ps

interface chbl_body_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface chbl_result_if import chbl_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [LEN_OUT_W-1:0] total_length;

	modport source (output valid, output status, output total_length, input ready);
	modport sink   (input valid, input status, input total_length, output ready);
endinterface

// ----- rtl/chunked_body_length_checker.sv -----
// Chunked body length checker: per-byte framing check of a chunked body.
// The result item of an accepted byte is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle while result.ready is high; the output register refills as it drains.
// Reset (arst_n low, asynchronous): phase to size digits, counters and total to zero,
// status to in progress, no result pending.
// Depends on chbl_pkg and chbl_if.
`timescale 1ns / 1ps

module chunked_body_length_checker import chbl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	chbl_body_if.sink             body,
	chbl_result_if.source         result
);

	// Framing state
	phase_t  phase_q, phase_d;
	size_t   chunk_size_q, chunk_size_d;
	size_t   remaining_q, remaining_d;
	total_t  length_sum_q, length_sum_d;
	status_t status_q, status_d;

	// Result register
	logic                 res_valid_q;
	logic [1:0]           res_status_q;
	logic [LEN_OUT_W-1:0] res_total_q;

	logic       accept;
	hex_t       hex;
	sum_t       sum_ext;
	logic       sum_ovf;
	logic       size_ovf;
	logic [EXT_W-1:0] total_ext;

	// Take a new item whenever the result register is empty or being drained.
	assign body.ready = !res_valid_q || result.ready;
	assign accept     = body.valid && body.ready;

	assign hex      = hex_decode(body.data_byte);
	// Another digit would push the size past SIZE_WIDTH bits.
	assign size_ovf = |chunk_size_q[SIZE_WIDTH-1 -: 4];
	// Carry out of the running total when this chunk is added.
	assign sum_ext  = SUM_WIDTH'(length_sum_q) + SUM_WIDTH'(chunk_size_q);
	assign sum_ovf  = |sum_ext[SUM_WIDTH-1:TOTAL_WIDTH];

	// Next state of the framing machine
	always_comb begin
		phase_d      = phase_q;
		chunk_size_d = chunk_size_q;
		remaining_d  = remaining_q;
		length_sum_d = length_sum_q;
		status_d     = status_q;
		if (status_q == ST_BUSY) begin
			if (body.end_of_input) begin
				// Stream ended early: size line vs. data framing.
				if (phase_q == PH_DIGITS || phase_q == PH_SIZE_LF) begin
					status_d = ST_SIZE_ERR;
				end else begin
					status_d = ST_FRAME_ERR;
				end
			end else begin
				unique case (phase_q)
					PH_DIGITS: begin
						if (body.data_byte == CH_CR) begin
							phase_d = PH_SIZE_LF;
						end else if (!hex.ok || size_ovf) begin
							status_d = ST_SIZE_ERR;
						end else begin
							chunk_size_d = {chunk_size_q[SIZE_WIDTH-5:0], hex.value};
						end
					end
					PH_SIZE_LF: begin
						if (body.data_byte != CH_LF) begin
							status_d = ST_SIZE_ERR;
						end else if (chunk_size_q == '0) begin
							// Last chunk: body complete, trailer ignored from here.
							phase_d  = PH_DONE;
							status_d = ST_DONE;
						end else if (sum_ovf) begin
							status_d = ST_SIZE_ERR;
						end else begin
							remaining_d = chunk_size_q;
							phase_d     = PH_DATA;
						end
					end
					PH_DATA: begin
						// Count down data bytes; any value is payload.
						remaining_d = remaining_q - SIZE_WIDTH'(1);
						if (remaining_q == SIZE_WIDTH'(1)) begin
							phase_d = PH_DATA_CR;
						end
					end
					PH_DATA_CR: begin
						if (body.data_byte != CH_CR) begin
							status_d = ST_FRAME_ERR;
						end else begin
							phase_d = PH_DATA_LF;
						end
					end
					PH_DATA_LF: begin
						if (body.data_byte != CH_LF) begin
							status_d = ST_FRAME_ERR;
						end else begin
							// Chunk closed: fold its size into the total.
							length_sum_d = sum_ext[TOTAL_WIDTH-1:0];
							chunk_size_d = '0;
							remaining_d  = '0;
							phase_d      = PH_DIGITS;
						end
					end
					PH_DONE: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result fields follow the updated state.
	always_comb begin
		total_ext           = EXT_W'(length_sum_d);
		result.valid        = res_valid_q;
		result.status       = res_status_q;
		result.total_length = res_total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DIGITS;
			chunk_size_q <= '0;
			remaining_q  <= '0;
			length_sum_q <= '0;
			status_q     <= ST_BUSY;
			res_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				phase_q      <= phase_d;
				chunk_size_q <= chunk_size_d;
				remaining_q  <= remaining_d;
				length_sum_q <= length_sum_d;
				status_q     <= status_d;
				res_valid_q  <= 1'b1;
			end else if (result.ready) begin
				res_valid_q  <= 1'b0;
			end
		end
	end

	// Load the result payload with each accepted item.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= status_d;
			res_total_q  <= total_ext[LEN_OUT_W-1:0];
		end
	end

	// An error or completion never changes once reached.
	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status_q != ST_BUSY |=> status_q == $past(status_q))
		else $error("status changed after leaving in progress");

	// The done phase is only reached together with complete status.
	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> status_q == ST_DONE)
		else $error("done phase without complete status");

	// Inside data the countdown never sits at zero.
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> remaining_q != '0)
		else $error("data phase with zero bytes remaining");

	// A pending result is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |-> !accept)
		else $error("item accepted over a pending result");

endmodule

// ----- tb/chunked_body_length_checker_test.sv -----
// Testbench for the chunked body length checker: drives one chunked body byte by byte
// and checks every status and running-length item against its own framing tracker or a hand-typed value.
// Depends on chbl_pkg, chbl_if and the chunked_body_length_checker RTL.
`timescale 1ns / 1ps

module chunked_body_length_checker_test;
	import chbl_pkg::*;

	// Give up after this many cycles in which neither side moves an item.
	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned BODY_ITEMS  = 1750;
	localparam int unsigned PRESSURE_AT = 900;
	localparam int unsigned SHOWN_FAULTS = 10;

	typedef struct packed {
		status_t              status;
		logic [LEN_OUT_W-1:0] total;
	} length_report_t;

	// One row of the opening script; typed rows carry the result by hand.
	typedef struct packed {
		logic [7:0]           b;
		logic                 eoi;
		logic                 typed;
		status_t              status;
		logic [LEN_OUT_W-1:0] total;
	} script_row_t;

	// The way the body is closed once the random chunks are through.
	typedef enum int unsigned {
		END_ZERO_CHUNK,
		END_EMPTY_SIZE,
		END_BAD_CHAR,
		END_UPPER_HEX,
		END_SIZE_NO_LF,
		END_SIZE_OVERFLOW,
		END_TOTAL_OVERFLOW,
		END_EOI_DIGITS,
		END_EOI_SIZE_LF,
		END_EOI_DATA,
		END_EOI_DATA_CR,
		END_EOI_DATA_LF,
		END_NO_DATA_CR,
		END_NO_DATA_LF
	} body_ending_t;

	// Two chunks of size one and two, then a size-three chunk left to the tracker up to its closing LF.
	localparam script_row_t OPENING [23] = '{
		'{"1",   1'b0, 1'b1, ST_BUSY, 32'd0},
		'{CH_CR, 1'b0, 1'b1, ST_BUSY, 32'd0},
		'{CH_LF, 1'b0, 1'b1, ST_BUSY, 32'd0},
		'{8'hff, 1'b0, 1'b1, ST_BUSY, 32'd0},
		'{CH_CR, 1'b0, 1'b1, ST_BUSY, 32'd0},
		'{CH_LF, 1'b0, 1'b1, ST_BUSY, 32'd1},
		'{"0",   1'b0, 1'b1, ST_BUSY, 32'd1},
		'{"0",   1'b0, 1'b1, ST_BUSY, 32'd1},
		'{"2",   1'b0, 1'b1, ST_BUSY, 32'd1},
		'{CH_CR, 1'b0, 1'b1, ST_BUSY, 32'd1},
		'{CH_LF, 1'b0, 1'b1, ST_BUSY, 32'd1},
		'{8'h00, 1'b0, 1'b1, ST_BUSY, 32'd1},
		'{CH_CR, 1'b0, 1'b1, ST_BUSY, 32'd1},
		'{CH_CR, 1'b0, 1'b1, ST_BUSY, 32'd1},
		'{CH_LF, 1'b0, 1'b1, ST_BUSY, 32'd3},
		'{"3",   1'b0, 1'b0, ST_BUSY, 32'd0},
		'{CH_CR, 1'b0, 1'b0, ST_BUSY, 32'd0},
		'{CH_LF, 1'b0, 1'b0, ST_BUSY, 32'd0},
		'{8'h55, 1'b0, 1'b0, ST_BUSY, 32'd0},
		'{8'haa, 1'b0, 1'b0, ST_BUSY, 32'd0},
		'{8'h7f, 1'b0, 1'b0, ST_BUSY, 32'd0},
		'{CH_CR, 1'b0, 1'b0, ST_BUSY, 32'd0},
		'{CH_LF, 1'b0, 1'b1, ST_BUSY, 32'd6}
	};

	logic clk = 1'b0;
	logic arst_n;

	chbl_body_if   body_ch();
	chbl_result_if result_ch();

	chunked_body_length_checker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	// Framing tracker state: our own picture of where the body stands.
	phase_t  trk_phase;
	size_t   trk_size;
	size_t   trk_left;
	total_t  trk_sum;
	status_t trk_status;

	length_report_t reports_due[$];
	int unsigned    sent;
	int unsigned    faults;
	int unsigned    checked;
	int unsigned    idle_cycles;
	bit             steady;

	function automatic bit lc_hex(input logic [7:0] b, output logic [3:0] v);
		v = 4'd0;
		if (b >= "0" && b <= "9") begin
			v = 4'(b - "0");
			return 1'b1;
		end
		if (b >= "a" && b <= "f") begin
			v = 4'(b - "a" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10)
			return 8'("0") + 8'(n);
		return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
	endfunction

	// Data bytes lean toward CR and LF so that framing characters show up as payload.
	function automatic logic [7:0] payload_byte();
		case ($urandom_range(0, 7))
			0: begin
				return CH_CR;
			end
			1: begin
				return CH_LF;
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	function automatic int unsigned draw_gap();
		return steady ? 0 : $urandom_range(0, 11);
	endfunction

	// Advance the tracker by one accepted item and report what the block must show.
	task automatic track_byte(input logic [7:0] b, input logic eoi, output length_report_t r);
		logic [3:0] v;
		bit         ok;
		begin
			if (trk_status == ST_BUSY) begin
				if (eoi) begin
					// End of stream: inside a size line it is a size error, else framing.
					if (trk_phase == PH_DIGITS || trk_phase == PH_SIZE_LF)
						trk_status = ST_SIZE_ERR;
					else
						trk_status = ST_FRAME_ERR;
				end else begin
					case (trk_phase)
						PH_DIGITS: begin
							if (b == CH_CR) begin
								trk_phase = PH_SIZE_LF;
							end else begin
								ok = lc_hex(b, v);
								// Drop to error on a non-digit or when another
								// nibble would push the size out of range.
								if (!ok || trk_size[SIZE_WIDTH-1 -: 4] != 4'd0)
									trk_status = ST_SIZE_ERR;
								else
									trk_size = {trk_size[SIZE_WIDTH-5:0], v};
							end
						end
						PH_SIZE_LF: begin
							if (b != CH_LF) begin
								trk_status = ST_SIZE_ERR;
							end else if (trk_size == '0) begin
								trk_phase  = PH_DONE;
								trk_status = ST_DONE;
							end else if (sum_t'(trk_size) + sum_t'(trk_sum) >
									sum_t'({TOTAL_WIDTH{1'b1}})) begin
								// The running total would no longer fit.
								trk_status = ST_SIZE_ERR;
							end else begin
								trk_left  = trk_size;
								trk_phase = PH_DATA;
							end
						end
						PH_DATA: begin
							trk_left = trk_left - 1'b1;
							if (trk_left == '0)
								trk_phase = PH_DATA_CR;
						end
						PH_DATA_CR: begin
							if (b != CH_CR)
								trk_status = ST_FRAME_ERR;
							else
								trk_phase = PH_DATA_LF;
						end
						PH_DATA_LF: begin
							if (b != CH_LF) begin
								trk_status = ST_FRAME_ERR;
							end else begin
								// Chunk closed cleanly: fold its size into the total.
								trk_sum   = total_t'(sum_t'(trk_sum) + sum_t'(trk_size));
								trk_size  = '0;
								trk_left  = '0;
								trk_phase = PH_DIGITS;
							end
						end
						default: begin
						end
					endcase
				end
			end
			r.status = trk_status;
			r.total  = LEN_OUT_W'(trk_sum);
		end
	endtask

	// Offer one item after a random gap, hold it until taken, then log its expectation.
	task automatic send_item(input logic [7:0] b, input logic eoi, input logic typed,
			input status_t st, input logic [LEN_OUT_W-1:0] len);
		int unsigned    gap;
		length_report_t r;
		begin
			gap = draw_gap();
			if (gap != 0) begin
				body_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			body_ch.valid        <= 1'b1;
			body_ch.data_byte    <= b;
			body_ch.end_of_input <= eoi;
			do @(posedge clk); while (!body_ch.ready);
			track_byte(b, eoi, r);
			if (typed) begin
				r.status = st;
				r.total  = len;
			end
			reports_due.push_back(r);
			sent++;
			// Switch between bursty and gap-free stretches now and then.
			if (sent % 150 == 0)
				steady = ($urandom_range(0, 3) == 0);
		end
	endtask

	task automatic send(input logic [7:0] b);
		send_item(b, 1'b0, 1'b0, ST_BUSY, '0);
	endtask

	task automatic send_eoi();
		send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, ST_BUSY, '0);
	endtask

	// Emit the hex digits of n after some leading zeros; n of zero with no zeros is empty.
	task automatic send_size_digits(input size_t n, input int unsigned zeros);
		bit started;
		begin
			started = 1'b0;
			repeat (zeros) send("0");
			for (int i = SIZE_WIDTH / 4 - 1; i >= 0; i--) begin
				if (n[i*4 +: 4] != 4'd0 || started) begin
					started = 1'b1;
					send(hex_char(n[i*4 +: 4], 1'b0));
				end
			end
		end
	endtask

	task automatic send_size_line(input size_t n);
		begin
			send_size_digits(n, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) :
					$urandom_range(0, 1));
			send(CH_CR);
			send(CH_LF);
		end
	endtask

	task automatic send_payload(input int unsigned n);
		repeat (n) send(payload_byte());
	endtask

	task automatic send_chunk(input size_t n);
		begin
			send_size_line(n);
			send_payload(n);
			send(CH_CR);
			send(CH_LF);
		end
	endtask

	// Close the body in one of the ways it can end; every one of them is sticky.
	task automatic send_ending(input body_ending_t how);
		logic [7:0] b;
		logic [3:0] v;
		size_t      n;
		begin
			case (how)
				END_ZERO_CHUNK: begin
					send_size_digits('0, $urandom_range(1, 3));
					send(CH_CR);
					send(CH_LF);
				end
				END_EMPTY_SIZE: begin
					send(CH_CR);
					send(CH_LF);
				end
				END_BAD_CHAR: begin
					send(hex_char(4'($urandom_range(1, 15)), 1'b0));
					do b = 8'($urandom_range(0, 255)); while (lc_hex(b, v) || b == CH_CR);
					send(b);
				end
				END_UPPER_HEX: begin
					send("1");
					send(hex_char(4'($urandom_range(10, 15)), 1'b1));
				end
				END_SIZE_NO_LF: begin
					send("5");
					send(CH_CR);
					do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
					send(b);
				end
				END_SIZE_OVERFLOW: begin
					// Nine significant digits: the ninth one overflows.
					send(hex_char(4'($urandom_range(1, 15)), 1'b0));
					repeat (SIZE_WIDTH / 4) send(hex_char(4'($urandom_range(0, 15)), 1'b0));
				end
				END_TOTAL_OVERFLOW: begin
					// Pick a size that fits alone but carries the total past its width.
					n = ~size_t'(trk_sum) + 1'b1 + size_t'($urandom_range(0, trk_sum - 1));
					send_size_line(n);
				end
				END_EOI_DIGITS: begin
					send("4");
					send_eoi();
				end
				END_EOI_SIZE_LF: begin
					send("4");
					send(CH_CR);
					send_eoi();
				end
				END_EOI_DATA: begin
					send_size_line(size_t'(4));
					send_payload(2);
					send_eoi();
				end
				END_EOI_DATA_CR: begin
					send_size_line(size_t'(2));
					send_payload(2);
					send_eoi();
				end
				END_EOI_DATA_LF: begin
					send_size_line(size_t'(2));
					send_payload(2);
					send(CH_CR);
					send_eoi();
				end
				END_NO_DATA_CR: begin
					send_size_line(size_t'(2));
					send_payload(2);
					do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
					send(b);
				end
				default: begin
					send_size_line(size_t'(2));
					send_payload(2);
					send(CH_CR);
					do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
					send(b);
				end
			endcase
		end
	endtask

	// Result side: stall for a random number of cycles, then hold ready until an item moves.
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int unsigned gap;
			gap = draw_gap();
			if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	// Check each result item against the oldest expectation and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (reports_due.size() == 0) begin
					if (faults < SHOWN_FAULTS)
						$display("unexpected result item: status %0d total %0d",
								result_ch.status, result_ch.total_length);
					faults++;
				end else begin
					length_report_t want;
					want = reports_due.pop_front();
					if (want.status != status_t'(result_ch.status) ||
							want.total != result_ch.total_length) begin
						if (faults < SHOWN_FAULTS)
							$display("result %0d: status exp %0d got %0d, total exp %0d got %0d",
									checked, want.status, result_ch.status,
									want.total, result_ch.total_length);
						faults++;
					end
					checked++;
				end
			end
			if ((result_ch.valid && result_ch.ready) || (body_ch.valid && body_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		body_ending_t how;
		int unsigned  big;
		bit           paused;
		trk_phase            = PH_DIGITS;
		trk_size             = '0;
		trk_left             = '0;
		trk_sum              = '0;
		trk_status           = ST_BUSY;
		sent                 = 0;
		faults               = 0;
		checked              = 0;
		steady               = 1'b0;
		paused               = 1'b0;
		idle_cycles          <= 0;
		arst_n               <= 1'b0;
		body_ch.valid        <= 1'b0;
		body_ch.data_byte    <= 8'h00;
		body_ch.end_of_input <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the opening script: size-one chunk, leading zeros, CR inside the data.
		foreach (OPENING[i])
			send_item(OPENING[i].b, OPENING[i].eoi, OPENING[i].typed,
					OPENING[i].status, OPENING[i].total);

		// Well-formed chunks with random sizes and content make up the bulk.
		while (sent < BODY_ITEMS) begin
			big = $urandom_range(0, 9);
			send_chunk(size_t'((big == 0) ? $urandom_range(17, 100) : $urandom_range(1, 16)));
			// Hold the sender once until the result side has drained completely.
			if (!paused && sent >= PRESSURE_AT) begin
				paused = 1'b1;
				body_ch.valid <= 1'b0;
				do @(posedge clk); while (reports_due.size() != 0);
			end
		end

		how = body_ending_t'($urandom_range(END_ZERO_CHUNK, END_NO_DATA_LF));
		send_ending(how);

		// Trailing bytes and stream ends must leave the final status untouched.
		repeat (40) begin
			if ($urandom_range(0, 3) == 0)
				send_eoi();
			else
				send(payload_byte());
		end
		body_ch.valid <= 1'b0;

		do @(posedge clk); while (reports_due.size() != 0);
		repeat (16) @(posedge clk);
		if (faults == 0 && reports_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/chbl_pkg.sv
rtl/chbl_if.sv
rtl/chunked_body_length_checker.sv
tb/chunked_body_length_checker_test.sv
